// ----- src/path_curve_flattener_defines.svh -----
// Assertion macros used by the flattener back end
`ifndef PATH_CURVE_FLATTENER_DEFINES_SVH
`define PATH_CURVE_FLATTENER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define PCF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcf check failed");

// Next-cycle implication, checked out of reset
`define PCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcf check failed");

`endif

// ----- src/pcf_pkg.sv -----
package pcf_pkg;

    // Points per curve
    localparam int SEGMENTS = 10;
    localparam int SEG_W    = $clog2(SEGMENTS);
    localparam longint ONE16 = 65536;

    typedef enum logic [2:0] {
        MODE_BEGIN,
        MODE_MOVE,
        MODE_LINE,
        MODE_QUAD,
        MODE_CUBIC,
        MODE_CLOSE,
        MODE_STROKE,
        MODE_FILL
    } mode_t;

    typedef enum logic [1:0] {
        KIND_POINT,
        KIND_STROKE,
        KIND_FILL
    } kind_t;

    typedef enum logic [1:0] {
        JOB_POINT,
        JOB_QUAD,
        JOB_CUBIC,
        JOB_COMMIT
    } job_op_t;

    // One unit of work handed from the front to the back
    typedef struct packed {
        job_op_t            op;
        kind_t              kind;
        logic signed [31:0] p0x;
        logic signed [31:0] p0y;
        logic signed [31:0] p1x;
        logic signed [31:0] p1y;
        logic signed [31:0] p2x;
        logic signed [31:0] p2y;
        logic signed [31:0] p3x;
        logic signed [31:0] p3y;
    } job_t;

    // Weight table selectors
    localparam int WSEL_Q0 = 0;
    localparam int WSEL_Q1 = 1;
    localparam int WSEL_Q2 = 2;
    localparam int WSEL_C0 = 3;
    localparam int WSEL_C1 = 4;
    localparam int WSEL_C2 = 5;
    localparam int WSEL_C3 = 6;

    typedef logic [16:0] wt_tab_t [SEGMENTS];

    // Bernstein weights in Q1.16, entry i is for t = (i+1)/SEGMENTS
    function automatic wt_tab_t calc_weights(input int sel);
        wt_tab_t tab;
        longint  t;
        longint  u;
        longint  q0;
        longint  q2;
        longint  c0;
        longint  c1;
        longint  c3;
        longint  w;
        for (int i = 0; i < SEGMENTS; i++)
        begin
            t  = ((longint'(i) + 1) * ONE16 + SEGMENTS / 2) / SEGMENTS;
            u  = ONE16 - t;
            q0 = (u * u + 32768) >>> 16;
            q2 = (t * t + 32768) >>> 16;
            c0 = (u * u * u + 64'sd2147483648) >>> 32;
            c1 = (3 * u * u * t + 64'sd2147483648) >>> 32;
            c3 = (t * t * t + 64'sd2147483648) >>> 32;
            case (sel)
                WSEL_Q0: w = q0;
                WSEL_Q1: w = ONE16 - q0 - q2;
                WSEL_Q2: w = q2;
                WSEL_C0: w = c0;
                WSEL_C1: w = c1;
                WSEL_C2: w = ONE16 - c0 - c1 - c3;
                WSEL_C3: w = c3;
                default: w = 0;
            endcase
            tab[i] = w[16:0];
        end
        return tab;
    endfunction

endpackage

// ----- src/pcf_queue.sv -----
module pcf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pcf_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output pcf_pkg::job_t  pop_job,
    output logic           empty
);
    import pcf_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_job = entry_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ----- src/pcf_front.sv -----
module pcf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  logic [2:0]         mode,
    input  logic signed [31:0] ax,
    input  logic signed [31:0] ay,
    input  logic signed [31:0] bx,
    input  logic signed [31:0] by_coord,
    input  logic signed [31:0] ex,
    input  logic signed [31:0] ey,
    input  logic               queue_full,
    output logic               push,
    output pcf_pkg::job_t      job
);
    import pcf_pkg::*;

    logic               active_reg, active_next;
    logic [1:0]         count_reg, count_next;
    logic signed [31:0] first_x_reg, first_x_next;
    logic signed [31:0] first_y_reg, first_y_next;
    logic signed [31:0] last_x_reg, last_x_next;
    logic signed [31:0] last_y_reg, last_y_next;
    logic [1:0]         eff_count;
    logic [1:0]         count_inc;
    logic               take;

    assign cmd_ready = !queue_full;
    assign take      = cmd_valid && cmd_ready;

    // classify the command and update path state
    always_comb
    begin
        active_next  = active_reg;
        count_next   = count_reg;
        first_x_next = first_x_reg;
        first_y_next = first_y_reg;
        last_x_next  = last_x_reg;
        last_y_next  = last_y_reg;
        eff_count    = active_reg ? count_reg : 2'd0;
        count_inc    = (count_reg == 2'd3) ? 2'd3 : count_reg + 2'd1;
        push         = 1'b0;
        job          = '{op: JOB_POINT, kind: KIND_POINT,
                         p0x: ax, p0y: ay, p1x: ax, p1y: ay,
                         p2x: bx, p2y: by_coord, p3x: ex, p3y: ey};
        case (mode_t'(mode))
            MODE_BEGIN:
            begin
                active_next = 1'b1;
                count_next  = 2'd0;
            end
            MODE_MOVE, MODE_LINE:
            begin
                active_next = 1'b1;
                if (eff_count == 2'd0)
                begin
                    first_x_next = ax;
                    first_y_next = ay;
                end
                last_x_next = ax;
                last_y_next = ay;
                count_next  = (eff_count == 2'd3) ? 2'd3 : eff_count + 2'd1;
                push        = 1'b1;
            end
            MODE_QUAD, MODE_CUBIC:
            begin
                if (active_reg && count_reg != 2'd0)
                begin
                    job.op      = (mode_t'(mode) == MODE_QUAD) ? JOB_QUAD : JOB_CUBIC;
                    job.p0x     = last_x_reg;
                    job.p0y     = last_y_reg;
                    last_x_next = ex;
                    last_y_next = ey;
                    count_next  = 2'd3;
                    push        = 1'b1;
                end
            end
            MODE_CLOSE:
            begin
                if (active_reg && count_reg != 2'd0)
                begin
                    job.p0x     = first_x_reg;
                    job.p0y     = first_y_reg;
                    last_x_next = first_x_reg;
                    last_y_next = first_y_reg;
                    count_next  = count_inc;
                    push        = 1'b1;
                end
            end
            MODE_STROKE:
            begin
                if (active_reg && count_reg >= 2'd2)
                begin
                    job.op      = JOB_COMMIT;
                    job.kind    = KIND_STROKE;
                    active_next = 1'b0;
                    push        = 1'b1;
                end
            end
            default:
            begin
                if (active_reg && count_reg == 2'd3)
                begin
                    job.op      = JOB_COMMIT;
                    job.kind    = KIND_FILL;
                    active_next = 1'b0;
                    push        = 1'b1;
                end
            end
        endcase
        push = push && take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            count_reg   <= 2'd0;
            first_x_reg <= '0;
            first_y_reg <= '0;
            last_x_reg  <= '0;
            last_y_reg  <= '0;
        end
        else if (take)
        begin
            active_reg  <= active_next;
            count_reg   <= count_next;
            first_x_reg <= first_x_next;
            first_y_reg <= first_y_next;
            last_x_reg  <= last_x_next;
            last_y_reg  <= last_y_next;
        end
    end

endmodule

// ----- src/pcf_back.sv -----
`include "path_curve_flattener_defines.svh"

module pcf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               queue_empty,
    input  pcf_pkg::job_t      queue_job,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output pcf_pkg::kind_t     kind,
    output logic               last
);
    import pcf_pkg::*;

    localparam wt_tab_t QW0 = calc_weights(WSEL_Q0);
    localparam wt_tab_t QW1 = calc_weights(WSEL_Q1);
    localparam wt_tab_t QW2 = calc_weights(WSEL_Q2);
    localparam wt_tab_t CW0 = calc_weights(WSEL_C0);
    localparam wt_tab_t CW1 = calc_weights(WSEL_C1);
    localparam wt_tab_t CW2 = calc_weights(WSEL_C2);
    localparam wt_tab_t CW3 = calc_weights(WSEL_C3);
    localparam logic [16:0] W_ONE = 17'h10000;
    localparam logic [SEG_W-1:0] IDX_LAST = SEG_W'(SEGMENTS - 1);

    logic advance;

    // stage 1: current job and segment index
    logic             s1_valid_reg;
    job_t             s1_job_reg;
    logic [SEG_W-1:0] s1_idx_reg;
    logic             s1_last;
    logic             s1_done;

    // stage 2: registered products
    logic               s2_valid_reg;
    logic signed [49:0] s2_px_reg [4];
    logic signed [49:0] s2_py_reg [4];
    kind_t              s2_kind_reg;
    logic               s2_last_reg;

    // stage 3: output register
    logic               out_valid_reg;
    logic signed [31:0] out_x_reg, out_x_next;
    logic signed [31:0] out_y_reg, out_y_next;
    kind_t              kind_reg;
    logic               last_reg;

    logic [16:0]        wt [4];
    logic signed [31:0] cx [4];
    logic signed [31:0] cy [4];
    logic signed [49:0] px [4];
    logic signed [49:0] py [4];
    logic signed [49:0] rx_full [4];
    logic signed [49:0] ry_full [4];
    logic signed [35:0] sum_x;
    logic signed [35:0] sum_y;

    assign advance = !out_valid_reg || out_ready;
    assign s1_last = (s1_job_reg.op != JOB_QUAD && s1_job_reg.op != JOB_CUBIC)
                     || (s1_idx_reg == IDX_LAST);
    assign s1_done = !s1_valid_reg || s1_last;
    assign pop     = advance && s1_done && !queue_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance && s1_done)
            s1_valid_reg <= !queue_empty;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_job_reg <= queue_job;
            s1_idx_reg <= '0;
        end
        else if (advance && !s1_done)
            s1_idx_reg <= s1_idx_reg + SEG_W'(1);
    end

    // weight selection per job type and the weighted products
    always_comb
    begin
        cx[0] = s1_job_reg.p0x;
        cx[1] = s1_job_reg.p1x;
        cx[2] = s1_job_reg.p2x;
        cx[3] = s1_job_reg.p3x;
        cy[0] = s1_job_reg.p0y;
        cy[1] = s1_job_reg.p1y;
        cy[2] = s1_job_reg.p2y;
        cy[3] = s1_job_reg.p3y;
        case (s1_job_reg.op)
            JOB_POINT:
            begin
                wt[0] = W_ONE;
                wt[1] = '0;
                wt[2] = '0;
                wt[3] = '0;
            end
            JOB_QUAD:
            begin
                wt[0] = QW0[s1_idx_reg];
                wt[1] = QW1[s1_idx_reg];
                wt[2] = '0;
                wt[3] = QW2[s1_idx_reg];
            end
            JOB_CUBIC:
            begin
                wt[0] = CW0[s1_idx_reg];
                wt[1] = CW1[s1_idx_reg];
                wt[2] = CW2[s1_idx_reg];
                wt[3] = CW3[s1_idx_reg];
            end
            default:
            begin
                wt[0] = '0;
                wt[1] = '0;
                wt[2] = '0;
                wt[3] = '0;
            end
        endcase
        for (int k = 0; k < 4; k++)
        begin
            px[k] = cx[k] * $signed({1'b0, wt[k]});
            py[k] = cy[k] * $signed({1'b0, wt[k]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (advance)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_px_reg   <= px;
            s2_py_reg   <= py;
            s2_kind_reg <= s1_job_reg.kind;
            s2_last_reg <= s1_last;
        end
    end

    // round each term, sum and saturate
    always_comb
    begin
        sum_x = '0;
        sum_y = '0;
        for (int k = 0; k < 4; k++)
        begin
            rx_full[k] = (s2_px_reg[k] + 50'sd32768) >>> 16;
            ry_full[k] = (s2_py_reg[k] + 50'sd32768) >>> 16;
            sum_x = sum_x + 36'(rx_full[k]);
            sum_y = sum_y + 36'(ry_full[k]);
        end
        if (sum_x > 36'sd2147483647)
            out_x_next = 32'sh7fffffff;
        else if (sum_x < -36'sd2147483648)
            out_x_next = 32'sh80000000;
        else
            out_x_next = sum_x[31:0];
        if (sum_y > 36'sd2147483647)
            out_y_next = 32'sh7fffffff;
        else if (sum_y < -36'sd2147483648)
            out_y_next = 32'sh80000000;
        else
            out_y_next = sum_y[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
            kind_reg  <= s2_kind_reg;
            last_reg  <= s2_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign kind      = kind_reg;
    assign last      = last_reg;

    `PCF_ASSERT_NOW(a_pop_when_done, pop, !s1_valid_reg || s1_last)
    `PCF_ASSERT_NOW(a_idx_range, s1_valid_reg, s1_idx_reg <= IDX_LAST)
    `PCF_ASSERT_NOW(a_commit_zero, out_valid_reg && kind_reg != KIND_POINT,
                    out_x_reg == 32'sd0 && out_y_reg == 32'sd0 && last_reg)
    `PCF_ASSERT_NEXT(a_stall_holds, out_valid_reg && !out_ready,
                     out_valid_reg && $stable(s1_idx_reg))

endmodule

// ----- src/path_curve_flattener.sv -----
// Path command flattener. Each transfer on the slave side is one path command;
// each transfer on the master side is one path point or a stroke/fill commit,
// with tlast on the final result of a command. A move, line, close or commit
// gives one result; a quadratic or cubic curve gives SEGMENTS (10) points, one
// per cycle unless the master side stalls, from the back end's eight multiplier
// lanes. Commands that produce nothing (begin, ignored curves/close/commits) are
// consumed at the input. A two-entry queue separates command decode from point
// generation; results then pass the stage 1, stage 2 and output registers.
module path_curve_flattener (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[2:0], ax, ay, bx, by_coord, ex, ey (32b each), zero pad to 200
    input  logic [199:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x[31:0], out_y[63:32]
    output logic [63:0]  m_axis_tdata,
    // kind[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    import pcf_pkg::*;

    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    job_t               push_job;
    job_t               pop_job;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    kind_t              out_kind;

    pcf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (s_axis_tvalid),
        .cmd_ready  (s_axis_tready),
        .mode       (s_axis_tdata[2:0]),
        .ax         (s_axis_tdata[34:3]),
        .ay         (s_axis_tdata[66:35]),
        .bx         (s_axis_tdata[98:67]),
        .by_coord   (s_axis_tdata[130:99]),
        .ex         (s_axis_tdata[162:131]),
        .ey         (s_axis_tdata[194:163]),
        .queue_full (q_full),
        .push       (q_push),
        .job        (push_job)
    );

    pcf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    pcf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (q_empty),
        .queue_job   (pop_job),
        .pop         (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_x       (out_x),
        .out_y       (out_y),
        .kind        (out_kind),
        .last        (m_axis_tlast)
    );

    assign m_axis_tdata = {out_y, out_x};
    assign m_axis_tuser = out_kind;

endmodule

// ----- tb/sv/tb_path_curve_flattener.sv -----
`timescale 1ns / 100ps

module tb_path_curve_flattener;
    import pcf_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // mode[2:0], ax, ay, bx, by_coord, ex, ey (32b each), zero pad to 200
    logic [199:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // out_x[31:0], out_y[63:32]
    logic [63:0]  m_axis_tdata;
    // kind[1:0]
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        kind_t              kind;
        bit                 last;
    } point_t;

    typedef struct {
        mode_t              mode;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by_coord;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        bit                 typed;   // result given by hand below
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        kind_t              tkind;
    } cmd_row_t;

    localparam logic signed [31:0] MAXC = 32'sh7fffffff;
    localparam logic signed [31:0] MINC = 32'sh80000000;
    localparam int CYCLE_LIMIT = 200000;

    // Predictor state
    bit     path_on;
    longint fx, fy, lx, ly;
    int     npts;

    point_t pending_pts[$];
    int     mismatches;
    int     cycles;
    int     idle_pct;
    int     stall_pct;
    bit     hold_rx;

    path_curve_flattener dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint rnd16(longint p);
        return (p + 32768) >>> 16;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Flatten one command into expected points; keep=0 only updates state
    task automatic flatten_cmd(input cmd_row_t c, input bit keep, output point_t res[$]);
        longint t, u, w0, w1, w2, w3, x, y;
        res = {};
        case (c.mode)
            MODE_BEGIN:
            begin
                path_on = 1;
                npts = 0;
            end
            MODE_MOVE, MODE_LINE:
            begin
                if (!path_on)
                begin
                    path_on = 1;
                    npts = 0;
                end
                if (npts == 0)
                begin
                    fx = c.ax;
                    fy = c.ay;
                end
                lx = c.ax;
                ly = c.ay;
                npts = (npts + 1 > 3) ? 3 : npts + 1;
                res = {res, point_t'{c.ax, c.ay, KIND_POINT, 1'b0}};
            end
            MODE_QUAD, MODE_CUBIC:
            begin
                if (path_on && npts != 0)
                begin
                    for (int i = 1; i <= SEGMENTS; i++)
                    begin
                        t = (i * ONE16 + SEGMENTS / 2) / SEGMENTS;
                        u = ONE16 - t;
                        if (i == SEGMENTS)
                        begin
                            x = c.ex;
                            y = c.ey;
                        end
                        else if (c.mode == MODE_QUAD)
                        begin
                            w0 = (u * u + 32768) >>> 16;
                            w2 = (t * t + 32768) >>> 16;
                            w1 = ONE16 - w0 - w2;
                            x = clamp32(rnd16(lx * w0) + rnd16(c.ax * w1) + rnd16(c.ex * w2));
                            y = clamp32(rnd16(ly * w0) + rnd16(c.ay * w1) + rnd16(c.ey * w2));
                        end
                        else
                        begin
                            w0 = (u * u * u + 64'sd2147483648) >>> 32;
                            w1 = (3 * u * u * t + 64'sd2147483648) >>> 32;
                            w3 = (t * t * t + 64'sd2147483648) >>> 32;
                            w2 = ONE16 - w0 - w1 - w3;
                            x = clamp32(rnd16(lx * w0) + rnd16(c.ax * w1)
                                        + rnd16(c.bx * w2) + rnd16(c.ex * w3));
                            y = clamp32(rnd16(ly * w0) + rnd16(c.ay * w1)
                                        + rnd16(c.by_coord * w2) + rnd16(c.ey * w3));
                        end
                        res = {res, point_t'{x[31:0], y[31:0], KIND_POINT, 1'b0}};
                    end
                    lx = c.ex;
                    ly = c.ey;
                    npts = 3;
                end
            end
            MODE_CLOSE:
            begin
                if (path_on && npts != 0)
                begin
                    lx = fx;
                    ly = fy;
                    npts = (npts + 1 > 3) ? 3 : npts + 1;
                    res = {res, point_t'{fx[31:0], fy[31:0], KIND_POINT, 1'b0}};
                end
            end
            default:
            begin
                if (path_on && npts >= ((c.mode == MODE_STROKE) ? 2 : 3))
                begin
                    path_on = 0;
                    res = {res, point_t'{32'sd0, 32'sd0,
                           (c.mode == MODE_STROKE) ? KIND_STROKE : KIND_FILL, 1'b0}};
                end
            end
        endcase
        if (res.size() > 0)
            res[res.size() - 1].last = 1'b1;
        if (keep)
            foreach (res[k])
                pending_pts = {pending_pts, res[k]};
    endtask

    // Offer one command, wait for its transfer, then record what it must produce
    task automatic send_cmd(input cmd_row_t c);
        point_t res[$];
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, c.ey, c.ex, c.by_coord, c.bx, c.ay, c.ax, c.mode};
        forever
        begin
            @(negedge clk);
            if (s_axis_tready)
                break;
        end
        @(posedge clk);
        flatten_cmd(c, !c.typed, res);
        if (c.typed)
            pending_pts = {pending_pts, point_t'{c.tx, c.ty, c.tkind, 1'b1}};
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            2: return $urandom_range(1) ? MAXC : MINC;
            default: return $urandom();
        endcase
    endfunction

    function automatic cmd_row_t rand_cmd();
        cmd_row_t c;
        int r;
        r = $urandom_range(99);
        if (r < 8)       c.mode = MODE_BEGIN;
        else if (r < 23) c.mode = MODE_MOVE;
        else if (r < 43) c.mode = MODE_LINE;
        else if (r < 58) c.mode = MODE_QUAD;
        else if (r < 73) c.mode = MODE_CUBIC;
        else if (r < 83) c.mode = MODE_CLOSE;
        else if (r < 92) c.mode = MODE_STROKE;
        else             c.mode = MODE_FILL;
        c.ax = rand_coord();
        c.ay = rand_coord();
        c.bx = rand_coord();
        c.by_coord = rand_coord();
        c.ex = rand_coord();
        c.ey = rand_coord();
        c.typed = 0;
        c.tx = 0;
        c.ty = 0;
        c.tkind = KIND_POINT;
        return c;
    endfunction

    // Result side: ready toggles at random, long hold-off from its own process
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !hold_rx && ($urandom_range(99) >= stall_pct);
    end

    // Compare each result transfer with the oldest expected point
    always @(negedge clk)
    begin
        point_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_pts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%h y=%h kind=%0d last=%b",
                             m_axis_tdata[31:0], m_axis_tdata[63:32],
                             m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                e = pending_pts.pop_front();
                if (m_axis_tdata[31:0] !== e.x || m_axis_tdata[63:32] !== e.y
                    || m_axis_tuser !== e.kind || m_axis_tlast !== e.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%h y=%h kind=%0d last=%b, got x=%h y=%h kind=%0d last=%b",
                                 e.x, e.y, e.kind, e.last, m_axis_tdata[31:0],
                                 m_axis_tdata[63:32], m_axis_tuser, m_axis_tlast);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_path_curve_flattener NOT OK");
            $finish;
        end
    end

    // Long receiver hold-off while commands keep coming
    initial
    begin
        hold_rx = 1'b0;
        wait (rst_n);
        repeat (60) @(posedge clk);
        hold_rx <= 1'b1;
        repeat (300) @(posedge clk);
        hold_rx <= 1'b0;
    end

    initial
    begin
        cmd_row_t rows[$];
        int n_rand;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        path_on = 0;
        fx = 0;
        fy = 0;
        lx = 0;
        ly = 0;
        npts = 0;
        mismatches = 0;
        cycles = 0;
        idle_pct = 31;
        stall_pct = 80;
        n_rand = 110;

        // Directed commands: ignored cases out of reset, extremes, every mode
        rows = {rows, cmd_row_t'{MODE_STROKE, 1, 2, 3, 4, 5, 6, 0, 0, 0, KIND_POINT}};
        rows = {rows, cmd_row_t'{MODE_QUAD, 1, 2, 3, 4, 5, 6, 0, 0, 0, KIND_POINT}};
        rows = {rows, cmd_row_t'{MODE_CLOSE, 1, 2, 3, 4, 5, 6, 0, 0, 0, KIND_POINT}};
        rows = {rows, cmd_row_t'{MODE_BEGIN, 7, 7, 7, 7, 7, 7, 0, 0, 0, KIND_POINT}};
        rows = {rows, cmd_row_t'{MODE_CUBIC, 1, 2, 3, 4, 5, 6, 0, 0, 0, KIND_POINT}};
        rows = {rows, cmd_row_t'{MODE_FILL, 1, 2, 3, 4, 5, 6, 0, 0, 0, KIND_POINT}};
        rows = {rows, cmd_row_t'{MODE_MOVE, MAXC, MINC, MAXC, MINC, MAXC, MINC,
                                 1, MAXC, MINC, KIND_POINT}};
        rows = {rows, cmd_row_t'{MODE_FILL, 0, 0, 0, 0, 0, 0, 0, 0, 0, KIND_POINT}};
        rows = {rows, cmd_row_t'{MODE_LINE, 0, 0, -1, -1, -1, -1, 1, 0, 0, KIND_POINT}};
        rows = {rows, cmd_row_t'{MODE_FILL, 0, 0, 0, 0, 0, 0, 0, 0, 0, KIND_POINT}};
        rows = {rows, cmd_row_t'{MODE_STROKE, -1, -1, -1, -1, -1, -1, 1, 0, 0,
                                 KIND_STROKE}};
        rows = {rows, cmd_row_t'{MODE_CLOSE, 0, 0, 0, 0, 0, 0, 0, 0, 0, KIND_POINT}};
        rows = {rows, cmd_row_t'{MODE_LINE, MINC, MAXC, 0, 0, 0, 0, 1, MINC, MAXC,
                                 KIND_POINT}};
        rows = {rows, cmd_row_t'{MODE_QUAD, MAXC, MAXC, 0, 0, MAXC, MINC, 0, 0, 0,
                                 KIND_POINT}};
        rows = {rows, cmd_row_t'{MODE_CUBIC, MAXC, MAXC, MAXC, MAXC, MINC, MINC,
                                 0, 0, 0, KIND_POINT}};
        rows = {rows, cmd_row_t'{MODE_CUBIC, MINC, MAXC, MINC, MAXC, 32'sh00010000,
                                 -32'sh00018000, 0, 0, 0, KIND_POINT}};
        rows = {rows, cmd_row_t'{MODE_QUAD, 32'sh12345678, -32'sh00ABCDEF, 0, 0, 0, 0,
                                 0, 0, 0, KIND_POINT}};
        rows = {rows, cmd_row_t'{MODE_CLOSE, 0, 0, 0, 0, 0, 0, 1, MINC, MAXC,
                                 KIND_POINT}};
        rows = {rows, cmd_row_t'{MODE_FILL, 0, 0, 0, 0, 0, 0, 1, 0, 0, KIND_FILL}};
        rows = {rows, cmd_row_t'{MODE_MOVE, 32'sh00050000, 32'sh00060000, 0, 0, 0, 0,
                                 1, 32'sh00050000, 32'sh00060000, KIND_POINT}};
        rows = {rows, cmd_row_t'{MODE_QUAD, 32'sh00070000, 32'sh00080000, 0, 0,
                                 32'sh00090000, 32'sh000A0000, 0, 0, 0, KIND_POINT}};
        rows = {rows, cmd_row_t'{MODE_STROKE, 0, 0, 0, 0, 0, 0, 1, 0, 0, KIND_STROKE}};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_cmd(rows[i]);

        // Random commands over three idling phases
        for (int i = 0; i < n_rand; i++)
        begin
            if (i == n_rand / 3)
            begin
                idle_pct = 80;
                stall_pct = 31;
            end
            else if (i == 2 * n_rand / 3)
            begin
                idle_pct = 0;
                stall_pct = 0;
            end
            send_cmd(rand_cmd());
        end
        s_axis_tvalid <= 1'b0;

        wait (pending_pts.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb_path_curve_flattener OK");
        else
            $display("tb_path_curve_flattener NOT OK");
        $finish;
    end

endmodule

// ----- path_curve_flattener.f -----
+incdir+src
src/pcf_pkg.sv
src/pcf_queue.sv
src/pcf_front.sv
src/pcf_back.sv
src/path_curve_flattener.sv
tb/sv/tb_path_curve_flattener.sv
